// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the list engine.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a synchronous active-low reset as the disable condition.
`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// A stalled request holds its valid and its payload until taken.
`define PLE_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
    `PLE_ASSERT(lbl, clk, rstn, vld && !rdy |=> vld && $stable(sig), msg)

`endif

// ===== hdl/ple_pkg.sv =====
// Shared types and constants of the positional list engine.
// No dependencies; used by ple_ctrl, ple_datapath, the top level and the checker.
package ple_pkg;

    // request fields, packed from bit 0 upwards
    localparam int ACT_W       = 4;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 9;
    localparam int ACT_LSB     = 0;
    localparam int VAL_LSB     = ACT_LSB + ACT_W;
    localparam int POS_LSB     = VAL_LSB + VAL_W;
    localparam int IN_TDATA_W  = 48;

    // result fields, packed from bit 0 upwards
    localparam int STAT_W      = 2;
    localparam int RES_W       = 32;
    localparam int CNT_W       = 9;
    localparam int STAT_LSB    = 0;
    localparam int RES_LSB     = STAT_LSB + STAT_W;
    localparam int CNT_LSB     = RES_LSB + RES_W;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CNT_LSB - CNT_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FIRST  = 4'd0,
        ACT_INS_LAST   = 4'd1,
        ACT_INS_AT     = 4'd2,
        ACT_DEL_FIRST  = 4'd3,
        ACT_DEL_LAST   = 4'd4,
        ACT_DEL_AT     = 4'd5,
        ACT_FIND_FIRST = 4'd6,
        ACT_FIND_LAST  = 4'd7,
        ACT_COUNT      = 4'd8,
        ACT_REVERSE    = 4'd9,
        ACT_CLEAR      = 4'd10,
        ACT_READ_AT    = 4'd11
    } t_act;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_stat;

    // controller to datapath
    typedef struct packed {
        logic  capture;   // latch the incoming request
        logic  setup;     // clear result, load walk pointers for the action
        logic  rd_ptr;    // read at walk pointer, advance it for shifts and scans
        logic  rd_end;    // read at end pointer
        logic  hold;      // keep read data for a swap
        logic  wr_ptr;    // write read data at walk pointer
        logic  wr_end;    // write held data at end pointer
        logic  swap_adv;  // close in both swap pointers
        logic  put_val;   // write request value at insert index, grow list
        logic  len_dec;   // shrink list by one
        logic  len_clr;   // empty the list
        logic  take_rd;   // result takes read data
        logic  post;      // load output register
        t_stat stat;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_act act;
        logic len_zero;
        logic full;
        logic ins_ok;     // position valid for an insert
        logic del_ok;     // position valid for a delete or read
        logic none;       // walk has no entries to move or visit
        logic walk_last;  // walk pointer sits on its last entry
        logic swap_go;    // swap pointers have not yet met
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

// ===== hdl/ple_ctrl.sv =====
// Sequencing state machine of the positional list engine.
// Depends on ple_pkg; drives ple_datapath through t_cmd and reads t_sts.
module ple_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ple_pkg::t_sts i_sts,
    output ple_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DRAIN,
        S_PUT,
        S_SHRINK,
        S_READ,
        S_READ_W,
        S_SWAP_RA,
        S_SWAP_RB,
        S_SWAP_WA,
        S_SWAP_WB,
        S_POST
    } t_state;

    t_state         r_state, n_state;
    ple_pkg::t_stat r_stat,  n_stat;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_stat  = r_stat;
        o_cmd   = '0;
        o_cmd.stat = r_stat;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_stat      = ple_pkg::ST_OK;
                n_state     = S_POST;
                case (i_sts.act)
                    ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST,
                    ple_pkg::ACT_INS_AT: begin
                        if (i_sts.act == ple_pkg::ACT_INS_AT && !i_sts.ins_ok) begin
                            n_stat = ple_pkg::ST_BADPOS;
                        end else if (i_sts.full) begin
                            n_stat = ple_pkg::ST_FULL;
                        end else if (i_sts.none) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST,
                    ple_pkg::ACT_DEL_AT: begin
                        if (i_sts.len_zero) begin
                            n_stat = ple_pkg::ST_EMPTY;
                        end else if (i_sts.act == ple_pkg::ACT_DEL_AT && !i_sts.del_ok) begin
                            n_stat = ple_pkg::ST_BADPOS;
                        end else if (i_sts.none) begin
                            n_state = S_SHRINK;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    ple_pkg::ACT_FIND_FIRST, ple_pkg::ACT_FIND_LAST,
                    ple_pkg::ACT_COUNT: begin
                        if (!i_sts.len_zero) begin
                            n_state = S_WALK;
                        end
                    end
                    ple_pkg::ACT_REVERSE: begin
                        if (!i_sts.none) begin
                            n_state = S_SWAP_RA;
                        end
                    end
                    ple_pkg::ACT_CLEAR: begin
                        o_cmd.len_clr = 1'b1;
                    end
                    ple_pkg::ACT_READ_AT: begin
                        if (!i_sts.del_ok) begin
                            n_stat = ple_pkg::ST_BADPOS;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_POST;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.rd_ptr = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read returns this cycle; the datapath retires it itself
                case (i_sts.act)
                    ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST,
                    ple_pkg::ACT_INS_AT: begin
                        n_state = S_PUT;
                    end
                    ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST,
                    ple_pkg::ACT_DEL_AT: begin
                        n_state = S_SHRINK;
                    end
                    default: begin
                        n_state = S_POST;
                    end
                endcase
            end
            S_PUT: begin
                o_cmd.put_val = 1'b1;
                n_state       = S_POST;
            end
            S_SHRINK: begin
                o_cmd.len_dec = 1'b1;
                n_state       = S_POST;
            end
            S_READ: begin
                o_cmd.rd_ptr = 1'b1;
                n_state      = S_READ_W;
            end
            S_READ_W: begin
                o_cmd.take_rd = 1'b1;
                n_state       = S_POST;
            end
            S_SWAP_RA: begin
                if (i_sts.swap_go) begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = S_SWAP_RB;
                end else begin
                    n_state = S_POST;
                end
            end
            S_SWAP_RB: begin
                o_cmd.hold   = 1'b1;
                o_cmd.rd_end = 1'b1;
                n_state      = S_SWAP_WA;
            end
            S_SWAP_WA: begin
                o_cmd.wr_ptr = 1'b1;
                n_state      = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                o_cmd.wr_end   = 1'b1;
                o_cmd.swap_adv = 1'b1;
                n_state        = S_SWAP_RA;
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stat  <= ple_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_stat  <= n_stat;
        end
    end

endmodule

// ===== hdl/ple_datapath.sv =====
// Entry memory, length, walk pointers and result/output registers of the list engine.
// Depends on ple_pkg; commanded by ple_ctrl.
module ple_datapath #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ple_pkg::t_cmd                    i_cmd,
    output ple_pkg::t_sts                    o_sts,
    input  logic [ple_pkg::IN_TDATA_W-1:0]   i_req_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [ple_pkg::OUT_TDATA_W-1:0]  o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        MD_NONE,
        MD_UP,
        MD_DN,
        MD_SCAN,
        MD_SWAP,
        MD_READ
    } t_mode;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    ple_pkg::t_act                  r_act;
    logic [DATA_WIDTH-1:0]          r_val;
    logic [ple_pkg::POS_W-1:0]      r_pos;
    logic [LW-1:0]                  r_len;
    logic [LW-1:0]                  r_ptr;
    logic [LW-1:0]                  r_end;
    t_mode                          r_mode;
    logic [DATA_WIDTH-1:0]          r_rd;
    logic [LW-1:0]                  r_tag;
    logic                           r_rd_vld;
    logic [DATA_WIDTH-1:0]          r_hold;
    logic [ple_pkg::RES_W-1:0]      r_res;
    logic                           r_found;
    logic                           r_out_vld;
    logic [ple_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [CW-1:0]                  w_pos_x;
    logic [CW-1:0]                  w_len_x;
    logic [LW-1:0]                  w_pos_m1;
    logic [LW-1:0]                  w_idx;
    t_mode                          w_mode;
    logic                           w_none;
    logic [LW-1:0]                  w_rd_ptr;
    logic                           w_re;
    logic                           w_we;
    logic [LW-1:0]                  w_waddr;
    logic [DATA_WIDTH-1:0]          w_wdata;
    logic                           w_wb;
    logic                           w_match;
    logic [ple_pkg::RES_W-1:0]      w_hit_pos;
    logic [DATA_WIDTH+ple_pkg::VAL_W-1:0] w_val_wide;
    logic [ple_pkg::RES_W+DATA_WIDTH-1:0] w_rd_wide;

    assign w_val_wide = {{DATA_WIDTH{1'b0}}, i_req_data[ple_pkg::VAL_LSB +: ple_pkg::VAL_W]};
    assign w_rd_wide  = {{ple_pkg::RES_W{1'b0}}, r_rd};

    assign w_pos_x  = CW'(r_pos);
    assign w_len_x  = CW'(r_len);
    assign w_pos_m1 = LW'(w_pos_x - CW'(1));

    // zero-based index the action works at
    always_comb begin
        case (r_act)
            ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_DEL_FIRST: w_idx = '0;
            ple_pkg::ACT_INS_LAST:                          w_idx = r_len;
            ple_pkg::ACT_DEL_LAST:                          w_idx = r_len - LW'(1);
            default:                                        w_idx = w_pos_m1;
        endcase
    end

    always_comb begin
        case (r_act)
            ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST, ple_pkg::ACT_INS_AT: begin
                w_mode = MD_UP;
                w_none = (w_idx == r_len);
            end
            ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST, ple_pkg::ACT_DEL_AT: begin
                w_mode = MD_DN;
                w_none = ((w_idx + LW'(1)) == r_len);
            end
            ple_pkg::ACT_FIND_FIRST, ple_pkg::ACT_FIND_LAST, ple_pkg::ACT_COUNT: begin
                w_mode = MD_SCAN;
                w_none = (r_len == '0);
            end
            ple_pkg::ACT_REVERSE: begin
                w_mode = MD_SWAP;
                w_none = (r_len < LW'(2));
            end
            ple_pkg::ACT_READ_AT: begin
                w_mode = MD_READ;
                w_none = 1'b0;
            end
            default: begin
                w_mode = MD_NONE;
                w_none = 1'b1;
            end
        endcase
    end

    // read port
    assign w_re     = i_cmd.rd_ptr | i_cmd.rd_end;
    assign w_rd_ptr = i_cmd.rd_end ? r_end : r_ptr;

    // write port: returned data of a shift lands one place up or down
    assign w_wb = r_rd_vld && (r_mode == MD_UP || r_mode == MD_DN);

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_tag;
        w_wdata = r_rd;
        if (i_cmd.put_val) begin
            w_waddr = w_idx;
            w_wdata = r_val;
        end else if (i_cmd.wr_ptr) begin
            w_waddr = r_ptr;
        end else if (i_cmd.wr_end) begin
            w_waddr = r_end;
            w_wdata = r_hold;
        end else if (w_wb) begin
            w_waddr = (r_mode == MD_UP) ? (r_tag + LW'(1)) : (r_tag - LW'(1));
        end else begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_rd_ptr[AW-1:0]];
        end
    end

    assign w_match   = r_rd_vld && (r_mode == MD_SCAN) && (r_rd == r_val);
    assign w_hit_pos = ple_pkg::RES_W'(r_tag) + ple_pkg::RES_W'(1);

    // request, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= ple_pkg::t_act'(i_req_data[ple_pkg::ACT_LSB +: ple_pkg::ACT_W]);
            r_val <= w_val_wide[DATA_WIDTH-1:0];
            r_pos <= i_req_data[ple_pkg::POS_LSB +: ple_pkg::POS_W];
        end

        if (w_re) begin
            r_tag <= w_rd_ptr;
        end

        if (i_cmd.hold) begin
            r_hold <= r_rd;
        end

        if (i_cmd.setup) begin
            case (w_mode)
                MD_UP: begin
                    r_ptr <= r_len - LW'(1);
                    r_end <= w_idx;
                end
                MD_DN: begin
                    r_ptr <= w_idx + LW'(1);
                    r_end <= r_len - LW'(1);
                end
                MD_SCAN, MD_SWAP: begin
                    r_ptr <= '0;
                    r_end <= r_len - LW'(1);
                end
                MD_READ: begin
                    r_ptr <= w_idx;
                    r_end <= w_idx;
                end
                default: begin
                    r_ptr <= '0;
                    r_end <= '0;
                end
            endcase
        end else if (i_cmd.swap_adv) begin
            r_ptr <= r_ptr + LW'(1);
            r_end <= r_end - LW'(1);
        end else if (i_cmd.rd_ptr) begin
            if (r_mode == MD_UP) begin
                r_ptr <= r_ptr - LW'(1);
            end else if (r_mode == MD_DN || r_mode == MD_SCAN) begin
                r_ptr <= r_ptr + LW'(1);
            end
        end

        if (i_cmd.setup) begin
            r_res <= '0;
        end else if (i_cmd.take_rd) begin
            r_res <= w_rd_wide[ple_pkg::RES_W-1:0];
        end else if (w_match) begin
            case (r_act)
                ple_pkg::ACT_FIND_FIRST: begin
                    if (!r_found) begin
                        r_res <= w_hit_pos;
                    end
                end
                ple_pkg::ACT_FIND_LAST: r_res <= w_hit_pos;
                ple_pkg::ACT_COUNT:     r_res <= r_res + ple_pkg::RES_W'(1);
                default:                r_res <= r_res;
            endcase
        end

        if (i_cmd.post) begin
            r_out_data <= {{ple_pkg::OUT_PAD_W{1'b0}}, ple_pkg::CNT_W'(r_len), r_res, i_cmd.stat};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_mode    <= MD_NONE;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_re;

            if (i_cmd.setup) begin
                r_mode <= w_mode;
            end

            if (i_cmd.len_clr) begin
                r_len <= '0;
            end else if (i_cmd.put_val) begin
                r_len <= r_len + LW'(1);
            end else if (i_cmd.len_dec) begin
                r_len <= r_len - LW'(1);
            end

            if (i_cmd.setup) begin
                r_found <= 1'b0;
            end else if (w_match) begin
                r_found <= 1'b1;
            end

            if (i_cmd.post) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.act       = r_act;
    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.full      = (r_len == LW'(DEPTH));
    assign o_sts.ins_ok    = (w_pos_x != '0) && (w_pos_x <= (w_len_x + CW'(1)));
    assign o_sts.del_ok    = (w_pos_x != '0) && (w_pos_x <= w_len_x);
    assign o_sts.none      = w_none;
    assign o_sts.walk_last = (r_ptr == r_end);
    assign o_sts.swap_go   = (r_ptr < r_end);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: an ordered list of up to DEPTH values.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
// Usage
//   Requests arrive on the s_axis channel, one operation each: insert, delete,
//   find first/last, count, reverse, clear or read at a 1-based position. Every
//   request yields exactly one result on m_axis: a status code, a result value
//   (found position, match count or read data, else zero) and the entry count
//   after the operation.
//   The list lives in a single-port-write, single-port-read memory of DEPTH
//   entries. One request is worked at a time; s_axis_tready is high only while
//   the sequencer is idle. Inserts and deletes shift the entries behind the
//   position, find and count compare every entry, and reverse swaps pairs
//   from both ends inward; clear and read at a position need no walk.
//   The next request can be taken in the cycle after its result is loaded.
//   The memory port sets the pace: one entry is moved or compared per cycle,
//   and a swap needs two reads and two writes.
//   The result sits in an output register. A stalled receiver holds the result
//   there; the block finishes its current request meanwhile and waits in its
//   final step only if the register is still occupied.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result; stored entries are not cleared and are never read before written.
module positional_list_engine #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] action, [35:4] value, [44:36] position, [47:45] zero
    input  logic [ple_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [33:2] result_value, [42:34] entry_count, [47:43] zero
    output logic [ple_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    ple_pkg::t_cmd w_cmd;
    ple_pkg::t_sts w_sts;

    // sequencer: decodes the request and steps the memory walks
    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage, pointers, comparison and the output register
    ple_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_data  (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/ple_checker.sv =====
// Port-level checks of the positional list engine, bound to the top level.
// Depends on ple_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ple_checker #(
    parameter int DEPTH = 256
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [ple_pkg::STAT_W-1:0] w_stat;
    logic [ple_pkg::RES_W-1:0]  w_res;
    logic [ple_pkg::CNT_W-1:0]  w_cnt;
    logic [31:0]                w_cnt_wide;
    logic [31:0]                w_depth;
    logic [ple_pkg::CNT_W-1:0]  w_depth_cnt;

    assign w_stat      = m_axis_tdata[ple_pkg::STAT_LSB +: ple_pkg::STAT_W];
    assign w_res       = m_axis_tdata[ple_pkg::RES_LSB +: ple_pkg::RES_W];
    assign w_cnt       = m_axis_tdata[ple_pkg::CNT_LSB +: ple_pkg::CNT_W];
    assign w_cnt_wide  = 32'(w_cnt);
    assign w_depth     = 32'(DEPTH);
    assign w_depth_cnt = ple_pkg::CNT_W'(DEPTH);

    // one request in work at a time
    `PLE_ASSERT(a_one_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while another was in work")

    `PLE_ASSERT_HOLD(a_result_hold, i_clk, i_rst_n, m_axis_tvalid, m_axis_tready, m_axis_tdata, "stalled result changed")

    `PLE_ASSERT(a_count_bound, i_clk, i_rst_n, m_axis_tvalid |-> w_cnt_wide <= w_depth, "entry count above capacity")

    `PLE_ASSERT(a_full_count, i_clk, i_rst_n, m_axis_tvalid && w_stat == ple_pkg::ST_FULL |-> w_cnt == w_depth_cnt, "full status with list not full")

    `PLE_ASSERT(a_empty_result, i_clk, i_rst_n, m_axis_tvalid && w_stat == ple_pkg::ST_EMPTY |-> w_cnt == '0 && w_res == '0, "empty status with entries or a result")

endmodule

bind positional_list_engine ple_checker #(
    .DEPTH (DEPTH)
) u_ple_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the positional list engine: requests in, one result out each.
// Depends on ple_pkg and positional_list_engine; a shadow list predicts every result.
module tb_positional_list_engine;

    localparam int LIST_DEPTH    = 256;
    localparam int DATA_W        = 32;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_OFF      = 300;   // long receiver stall for the back-pressure test
    localparam int DRAIN_CYCLES  = 600;   // above the slowest request (reverse of a full list)
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake on either side
    localparam int MAX_REPORTS   = 50;
    localparam int IN_PAD_W      = ple_pkg::IN_TDATA_W - ple_pkg::POS_LSB - ple_pkg::POS_W;

    // action codes that the block treats as no operation
    localparam logic [ple_pkg::ACT_W-1:0] ACT_SPARE_LO = 4'd12;
    localparam logic [ple_pkg::ACT_W-1:0] ACT_SPARE_HI = 4'd15;

    typedef struct packed {
        ple_pkg::t_stat            status;
        logic [ple_pkg::RES_W-1:0] value;
        logic [ple_pkg::CNT_W-1:0] count;
    } t_list_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [3:0] action, [35:4] value, [44:36] position, [47:45] zero
    logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [1:0] status, [33:2] result_value, [42:34] entry_count, [47:43] zero
    logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow copy of the list and the results still owed by the block
    logic [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int                shadow_len = 0;
    t_list_result      pending_results [$];

    int  mismatches = 0;
    bit  src_idle = 1'b0;
    bit  sink_idle = 1'b0;
    int  sink_hold_cycles = 0;

    // keys that recur often enough for searches to hit
    logic [DATA_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                        32'h8000_0000, 32'h1234_5678, 32'hA5A5_A5A5,
                                        32'h5A5A_5A5A, 32'h0000_00FF};

    positional_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow list and return the result the block owes for it.
    function automatic t_list_result apply_list_op(input logic [ple_pkg::ACT_W-1:0] op,
                                                   input logic [ple_pkg::VAL_W-1:0] val,
                                                   input logic [ple_pkg::POS_W-1:0] pos);
        t_list_result      r;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] tmp;
        int                idx;
        int                i;
        int                j;
        r.status = ple_pkg::ST_OK;
        r.value  = '0;
        key      = val[DATA_W-1:0];
        case (op)
            ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST, ple_pkg::ACT_INS_AT: begin
                if (op == ple_pkg::ACT_INS_FIRST) begin
                    idx = 0;
                end else if (op == ple_pkg::ACT_INS_LAST) begin
                    idx = shadow_len;
                end else begin
                    idx = int'(pos) - 1;
                end
                // a bad position wins over a full list
                if (op == ple_pkg::ACT_INS_AT && (pos == 0 || int'(pos) > shadow_len + 1)) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else if (shadow_len >= LIST_DEPTH) begin
                    r.status = ple_pkg::ST_FULL;
                end else begin
                    for (i = shadow_len; i > idx; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[idx] = key;
                    shadow_len++;
                end
            end
            ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST, ple_pkg::ACT_DEL_AT: begin
                if (shadow_len == 0) begin
                    r.status = ple_pkg::ST_EMPTY;
                end else if (op == ple_pkg::ACT_DEL_AT && (pos == 0 || int'(pos) > shadow_len))
                begin
                    r.status = ple_pkg::ST_BADPOS;
                end else begin
                    if (op == ple_pkg::ACT_DEL_FIRST) begin
                        idx = 0;
                    end else if (op == ple_pkg::ACT_DEL_LAST) begin
                        idx = shadow_len - 1;
                    end else begin
                        idx = int'(pos) - 1;
                    end
                    for (i = idx; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            ple_pkg::ACT_FIND_FIRST: begin
                for (i = 0; i < shadow_len; i++)
                    if (r.value == 0 && shadow_list[i] == key)
                        r.value = ple_pkg::RES_W'(i + 1);
            end
            ple_pkg::ACT_FIND_LAST: begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_list[i] == key) r.value = ple_pkg::RES_W'(i + 1);
            end
            ple_pkg::ACT_COUNT: begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_list[i] == key) r.value = r.value + ple_pkg::RES_W'(1);
            end
            ple_pkg::ACT_REVERSE: begin
                i = 0;
                j = shadow_len - 1;
                while (i < j) begin
                    tmp            = shadow_list[i];
                    shadow_list[i] = shadow_list[j];
                    shadow_list[j] = tmp;
                    i++;
                    j--;
                end
            end
            ple_pkg::ACT_CLEAR: begin
                shadow_len = 0;
            end
            ple_pkg::ACT_READ_AT: begin
                if (pos == 0 || int'(pos) > shadow_len) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else begin
                    r.value = ple_pkg::RES_W'(shadow_list[int'(pos) - 1]);
                end
            end
            default: ;
        endcase
        r.count = ple_pkg::CNT_W'(shadow_len);
        return r;
    endfunction

    function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return ple_pkg::VAL_W'(key_pool[3'($urandom_range(0, 7))]);
        return ple_pkg::VAL_W'($urandom);
    endfunction

    // Mostly a valid position up to limit; now and then zero, one past, or anything.
    function automatic logic [ple_pkg::POS_W-1:0] pick_pos(input int limit);
        int r;
        r = $urandom_range(0, 99);
        if (limit > 0 && r < 80) return ple_pkg::POS_W'($urandom_range(1, limit));
        if (r < 88) return '0;
        if (r < 95) return ple_pkg::POS_W'(limit + 1);
        return ple_pkg::POS_W'($urandom);
    endfunction

    // Weight the mix towards inserts while the list is short, deletes once it grows.
    function automatic logic [ple_pkg::ACT_W-1:0] pick_action(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (len > 48 && r < 38) r = r + 38;
        if (r < 12) return ple_pkg::ACT_INS_FIRST;
        if (r < 24) return ple_pkg::ACT_INS_LAST;
        if (r < 38) return ple_pkg::ACT_INS_AT;
        if (r < 45) return ple_pkg::ACT_DEL_FIRST;
        if (r < 52) return ple_pkg::ACT_DEL_LAST;
        if (r < 62) return ple_pkg::ACT_DEL_AT;
        if (r < 66) return ple_pkg::ACT_FIND_FIRST;
        if (r < 70) return ple_pkg::ACT_FIND_LAST;
        if (r < 74) return ple_pkg::ACT_COUNT;
        if (r < 88) return ple_pkg::ACT_READ_AT;
        if (r < 92) return ple_pkg::ACT_REVERSE;
        if (r < 94) return ple_pkg::ACT_CLEAR;
        if (r < 96) return ple_pkg::ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        return ple_pkg::ACT_READ_AT;
    endfunction

    // Offer one request, hold it until taken, then book the result it owes.
    task automatic push_request(input logic [ple_pkg::ACT_W-1:0] op,
                                input logic [ple_pkg::VAL_W-1:0] val,
                                input logic [ple_pkg::POS_W-1:0] pos);
        int gap;
        gap = src_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, pos, val, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_list_op(op, val, pos));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Empty-list corner cases, every action, field extremes and the spare codes.
    task automatic test_boundaries();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        push_request(ple_pkg::ACT_DEL_FIRST, 32'hFFFF_FFFF, 9'd1);
        push_request(ple_pkg::ACT_DEL_LAST, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_DEL_AT, 32'h0, 9'd1);
        push_request(ple_pkg::ACT_FIND_FIRST, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_COUNT, 32'h0, 9'd511);
        push_request(ple_pkg::ACT_REVERSE, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_CLEAR, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd1);
        push_request(ple_pkg::ACT_INS_AT, 32'h1, 9'd0);
        push_request(ple_pkg::ACT_INS_AT, 32'h1, 9'd2);
        push_request(ple_pkg::ACT_INS_FIRST, 32'hFFFF_FFFF, 9'd511);
        push_request(ple_pkg::ACT_REVERSE, 32'h0, 9'd0);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        push_request(ple_pkg::ACT_INS_LAST, 32'h0000_0000, 9'd0);
        push_request(ple_pkg::ACT_INS_AT, 32'hA5A5_A5A5, 9'd2);
        push_request(ple_pkg::ACT_INS_AT, 32'hFFFF_FFFF, 9'd4);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd511);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd4);
        push_request(ple_pkg::ACT_FIND_LAST, 32'hFFFF_FFFF, 9'd0);
        push_request(ple_pkg::ACT_REVERSE, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_FIND_FIRST, 32'hFFFF_FFFF, 9'd0);
        push_request(ple_pkg::ACT_DEL_AT, 32'h0, 9'd5);
        push_request(ple_pkg::ACT_DEL_AT, 32'h0, 9'd2);
        push_request(ACT_SPARE_LO, 32'hFFFF_FFFF, 9'd511);
        push_request(ACT_SPARE_HI, 32'hFFFF_FFFF, 9'd511);
        push_request(ple_pkg::ACT_CLEAR, 32'h0, 9'd0);
    endtask

    // Fill to capacity, then probe full-list inserts and whole-list walks.
    task automatic test_fill_to_capacity();
        int k;
        for (k = 0; k < LIST_DEPTH; k++) begin
            if (k % 64 == 0) begin
                src_idle  = 1'($urandom_range(0, 1));
                sink_idle = 1'($urandom_range(0, 1));
            end
            push_request(ple_pkg::ACT_INS_LAST, pick_value(), ple_pkg::POS_W'($urandom));
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        push_request(ple_pkg::ACT_INS_FIRST, pick_value(), 9'd1);
        push_request(ple_pkg::ACT_INS_LAST, pick_value(), 9'd1);
        push_request(ple_pkg::ACT_INS_AT, pick_value(), 9'd257);
        push_request(ple_pkg::ACT_INS_AT, pick_value(), 9'd258);
        push_request(ple_pkg::ACT_INS_AT, pick_value(), 9'd0);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd256);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd257);
        push_request(ple_pkg::ACT_FIND_LAST, pick_value(), 9'd0);
        push_request(ple_pkg::ACT_COUNT, pick_value(), 9'd0);
        push_request(ple_pkg::ACT_REVERSE, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_READ_AT, 32'h0, 9'd1);
        push_request(ple_pkg::ACT_DEL_AT, 32'h0, 9'd256);
        push_request(ple_pkg::ACT_DEL_FIRST, 32'h0, 9'd0);
        push_request(ple_pkg::ACT_INS_AT, pick_value(), 9'd128);
        push_request(ple_pkg::ACT_FIND_FIRST, pick_value(), 9'd0);
        push_request(ple_pkg::ACT_CLEAR, 32'h0, 9'd0);
    endtask

    // Stall the result side for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        int k;
        src_idle         = 1'b0;
        sink_hold_cycles = HOLD_OFF;
        for (k = 0; k < 12; k++)
            push_request((k % 3 == 2) ? ple_pkg::ACT_READ_AT : ple_pkg::ACT_INS_LAST,
                         pick_value(), pick_pos(shadow_len));
    endtask

    task automatic test_random_mix(input int n_items);
        int                        k;
        logic [ple_pkg::ACT_W-1:0] op;
        logic [ple_pkg::POS_W-1:0] pos;
        for (k = 0; k < n_items; k++) begin
            // change the idling pattern every few dozen requests; start with none
            if (k % 35 == 0) begin
                src_idle  = (k == 0) ? 1'b0 : 1'($urandom_range(0, 1));
                sink_idle = (k == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            end
            op = pick_action(shadow_len);
            case (op)
                ple_pkg::ACT_INS_AT:                      pos = pick_pos(shadow_len + 1);
                ple_pkg::ACT_DEL_AT, ple_pkg::ACT_READ_AT: pos = pick_pos(shadow_len);
                default:                                  pos = ple_pkg::POS_W'($urandom);
            endcase
            push_request(op, pick_value(), pos);
        end
    endtask

    // Result side: random stall per result, plus the long hold-off on request.
    initial begin : result_sink
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end
            stall = sink_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Compare each accepted result with the oldest one owed.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing owed", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[ple_pkg::STAT_LSB +: ple_pkg::STAT_W] !== want.status)
                    report_mismatch("status",
                                    32'(m_axis_tdata[ple_pkg::STAT_LSB +: ple_pkg::STAT_W]),
                                    32'(want.status));
                if (m_axis_tdata[ple_pkg::RES_LSB +: ple_pkg::RES_W] !== want.value)
                    report_mismatch("result_value",
                                    32'(m_axis_tdata[ple_pkg::RES_LSB +: ple_pkg::RES_W]),
                                    32'(want.value));
                if (m_axis_tdata[ple_pkg::CNT_LSB +: ple_pkg::CNT_W] !== want.count)
                    report_mismatch("entry_count",
                                    32'(m_axis_tdata[ple_pkg::CNT_LSB +: ple_pkg::CNT_W]),
                                    32'(want.count));
            end
        end
    end

    // End the run if neither side moves a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundaries();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_mix(260);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // catch any stray result after the last one owed
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
tb/tb_positional_list_engine.sv
